// ----- design/lrs_pkg.sv -----
`default_nettype none
package lrs_pkg;
    typedef enum logic [1:0] {
        K_ADD   = 2'd0,
        K_CLEAR = 2'd1,
        K_READ  = 2'd2,
        K_NONE  = 2'd3
    } t_kind;

    localparam int unsigned LOG10_2_Q30 = 323228497;
    localparam int unsigned RATIO_MAX   = 20'hFFFFF;
    localparam int unsigned RANK_MAX    = 17'h1FFFF;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] sample;
        logic        batch_end;
        logic [6:0]  capacity;
    } t_cmd;

    typedef struct packed {
        logic [6:0]  count;
        logic        ok;
        logic [5:0]  index;
        logic [19:0] log_ratio;
        logic [16:0] log_rank;
        logic        final_result;
    } t_res;
endpackage
`default_nettype wire

// ----- design/lrs_fifo.sv -----
`default_nettype none
module lrs_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr,
    input  wire lrs_pkg::t_cmd i_data,
    output logic               o_full,
    input  wire logic          i_rd,
    output logic               o_empty,
    output lrs_pkg::t_cmd      o_data
);
    import lrs_pkg::*;
    t_cmd       r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;

    assign o_full  = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr && !o_full) r_mem[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_wr && !o_full) r_wp <= r_wp + 2'd1;
            if (i_rd && !o_empty) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'((i_wr && !o_full) ? 1 : 0) - 3'((i_rd && !o_empty) ? 1 : 0);
        end
    end
endmodule
`default_nettype wire

// ----- design/lrs_log2.sv -----
`default_nettype none
// log2 in Q5.28, one squaring step per cycle (28 steps after a load)
module lrs_log2 (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [30:0] i_x,
    output logic             o_done,
    output logic [32:0]      o_log
);
    logic [4:0]  r_n;
    logic [31:0] r_m;
    logic [27:0] r_frac;
    logic [4:0]  r_step;
    logic        r_busy, r_zero;
    logic [4:0]  w_n;
    logic [63:0] w_sq;
    logic [33:0] w_m;

    always_comb begin
        w_n = '0;
        for (int i = 1; i < 31; i++) if (i_x[i]) w_n = 5'(i);
    end
    assign w_sq = 64'(r_m) * 64'(r_m);
    assign w_m  = w_sq[63:30];
    assign o_log = r_zero ? '0 : {r_n, r_frac};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1; r_step <= '0;
                r_n <= w_n; r_zero <= (i_x == '0);
                r_m <= 32'(i_x) << (5'd30 - w_n);
                r_frac <= '0;
            end else if (r_busy) begin
                if (w_m[31]) begin
                    r_m <= w_m[32:1]; r_frac <= {r_frac[26:0], 1'b1};
                end else begin
                    r_m <= w_m[31:0]; r_frac <= {r_frac[26:0], 1'b0};
                end
                r_step <= r_step + 5'd1;
                if (r_step == 5'd27) begin
                    r_busy <= 1'b0; o_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ----- design/lrs_back.sv -----
`default_nettype none
module lrs_back #(
    parameter int DEPTH = 64,
    parameter int FRAC_BITS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_empty,
    input  wire lrs_pkg::t_cmd i_cmd,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output lrs_pkg::t_res      o_res
);
    import lrs_pkg::*;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_INS_LOAD, S_INS_SHIFT, S_INS_NEXT, S_COMMIT,
        S_RD_START, S_RD_FETCH, S_RD_WAIT, S_RD_MUL, S_RD_OUT, S_OUT
    } t_state;

    t_state      r_state;
    logic [30:0] r_sorted [DEPTH];
    logic [30:0] r_staged [DEPTH];
    logic [CW-1:0] r_count, r_scount, r_i, r_pos, r_n;
    logic [30:0] r_min, r_v, r_rd;
    logic        r_bad;
    logic [32:0] r_lmin, r_lv, r_lr;
    logic [63:0] r_pr, r_pk;
    logic        r_lstart;
    logic [30:0] r_lx_a, r_lx_b;
    logic        w_da, w_db;
    logic [32:0] w_la, w_lb;
    logic        r_minpass;

    lrs_log2 u_la (.i_clk, .i_rst_n, .i_start(r_lstart), .i_x(r_lx_a),
        .o_done(w_da), .o_log(w_la));
    lrs_log2 u_lb (.i_clk, .i_rst_n, .i_start(r_lstart), .i_x(r_lx_b),
        .o_done(w_db), .o_log(w_lb));

    logic [31:0] w_s;
    logic        w_sbad;
    assign w_s = i_cmd.sample;
    assign w_sbad = w_s[31] || (w_s == '0);
    assign o_pop = (r_state == S_IDLE) && !i_empty;

    // log10 from a Q28 log2 difference; the caller saturates the result
    function automatic logic [63:0] f_l10(input logic [32:0] d);
        logic [63:0] p;
        p = 64'(d) * 64'(LOG10_2_Q30);
        return p >> (58 - FRAC_BITS);
    endfunction

    // single-word result that ends its run
    function automatic t_res f_fin(input logic [CW-1:0] cnt, input logic ok);
        t_res r;
        r = '0;
        r.count = 7'(cnt);
        r.ok = ok;
        r.final_result = 1'b1;
        return r;
    endfunction

    logic [32:0] w_d;
    assign w_d = (r_lv > r_lmin) ? r_lv - r_lmin : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; o_valid <= 1'b0; r_lstart <= 1'b0;
            r_count <= '0; r_scount <= '0; r_min <= '0; r_bad <= 1'b0;
        end else begin
            r_lstart <= 1'b0;
            r_rd <= r_sorted[AW'(r_pos - CW'(1))];
            unique case (r_state)
                S_IDLE: if (!i_empty) begin
                    unique case (i_cmd.kind)
                        K_ADD: begin
                            if (!w_sbad && r_scount != CW'(DEPTH))
                                r_staged[AW'(r_scount)] <= w_s[30:0];
                            if (!i_cmd.batch_end) begin
                                if (w_sbad || r_scount == CW'(DEPTH)) r_bad <= 1'b1;
                                else r_scount <= r_scount + CW'(1);
                            end else if (w_sbad || r_bad || r_scount == CW'(DEPTH) ||
                                (r_count + r_scount + CW'(1)) > (CW+1)'(DEPTH)) begin
                                r_scount <= '0; r_bad <= 1'b0;
                                o_res <= f_fin('0, 1'b0);
                                o_valid <= 1'b1; r_state <= S_OUT;
                            end else begin
                                r_scount <= r_scount + CW'(1);
                                r_i <= '0; r_state <= S_INS_LOAD;
                            end
                        end
                        K_CLEAR: begin
                            r_count <= '0; r_min <= '0; r_scount <= '0; r_bad <= 1'b0;
                        end
                        K_READ: begin
                            if (7'(r_count) > i_cmd.capacity) begin
                                o_res <= f_fin(r_count, 1'b0);
                                o_valid <= 1'b1; r_state <= S_OUT;
                            end else if (r_count == '0) begin
                                o_res <= f_fin('0, 1'b1);
                                o_valid <= 1'b1; r_state <= S_OUT;
                            end else begin
                                r_n <= r_count; r_i <= '0;
                                r_lx_a <= r_min; r_lx_b <= 31'd1; r_lstart <= 1'b1;
                                r_minpass <= 1'b1; r_state <= S_RD_WAIT;
                            end
                        end
                        default: ;
                    endcase
                end
                S_INS_LOAD: begin
                    if (r_i == r_scount) begin
                        // point the read port at the new smallest entry
                        r_pos <= r_count; r_state <= S_COMMIT;
                    end else begin
                        r_v <= r_staged[AW'(r_i)]; r_pos <= r_count;
                        r_state <= S_INS_NEXT;
                    end
                end
                S_INS_NEXT: r_state <= S_INS_SHIFT; // r_rd is entry pos-1 next cycle
                S_INS_SHIFT: begin
                    if (r_pos != '0 && r_rd < r_v) begin
                        r_sorted[AW'(r_pos)] <= r_rd;
                        r_pos <= r_pos - CW'(1);
                        r_state <= S_INS_NEXT;
                    end else begin
                        r_sorted[AW'(r_pos)] <= r_v;
                        r_count <= r_count + CW'(1);
                        r_i <= r_i + CW'(1);
                        r_state <= S_INS_LOAD;
                    end
                end
                S_COMMIT: begin
                    r_pos <= r_count; r_scount <= '0; r_bad <= 1'b0;
                    r_state <= S_RD_START;
                    r_minpass <= 1'b0;
                end
                S_RD_START: begin // r_rd = smallest entry after commit
                    r_min <= r_rd;
                    o_res <= f_fin(r_count, 1'b1);
                    o_valid <= 1'b1; r_state <= S_OUT;
                end
                S_RD_FETCH: begin
                    r_lx_a <= r_rd; r_lx_b <= 31'(r_n - r_i); r_lstart <= 1'b1;
                    r_state <= S_RD_WAIT;
                end
                S_RD_WAIT: if (w_da && w_db) begin
                    if (r_minpass) begin
                        r_lmin <= w_la;
                        r_pos <= r_n - r_i; r_state <= S_RD_MUL;
                    end else begin
                        r_lv <= w_la; r_lr <= w_lb; r_state <= S_RD_MUL;
                    end
                end
                S_RD_MUL: begin
                    if (r_minpass) begin
                        // r_pos was set by S_RD_WAIT, so r_rd holds the first value in S_RD_FETCH
                        r_minpass <= 1'b0; r_state <= S_RD_FETCH;
                    end else begin
                        r_pr <= f_l10(w_d); r_pk <= f_l10(r_lr);
                        r_state <= S_RD_OUT;
                    end
                end
                S_RD_OUT: begin
                    o_res.count <= 7'(r_n); o_res.ok <= 1'b1;
                    o_res.index <= 6'(r_i);
                    o_res.log_ratio <= (r_pr > 64'(RATIO_MAX)) ? 20'(RATIO_MAX) : r_pr[19:0];
                    o_res.log_rank <= (r_pk > 64'(RANK_MAX)) ? 17'(RANK_MAX) : r_pk[16:0];
                    o_res.final_result <= (r_i + CW'(1) == r_n);
                    // prefetch the next value while the word waits
                    r_pos <= r_n - r_i - CW'(1);
                    o_valid <= 1'b1; r_state <= S_OUT;
                end
                S_OUT: if (i_ready) begin
                    o_valid <= 1'b0;
                    if (o_res.final_result) r_state <= S_IDLE;
                    else begin
                        r_i <= r_i + CW'(1);
                        r_state <= S_RD_FETCH;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- design/log_rank_size_sorter_top.sv -----
`default_nettype none
// Rank-size sorter. Words enter a 4-deep queue and a sequencer executes them one at a
// time. A plain add word stages its sample, a clear empties the store, and a rejected
// batch end answers straight from idle. A committing batch end inserts each staged
// sample by shifting the store one entry at a time, then finds the new minimum and
// answers. A read over capacity or of an empty store gives one final word; else it
// first takes the log of the minimum, then emits one result per stored value, paced by
// the bit-serial log2 squaring loop (28 steps) and by output stalls.
module log_rank_size_sorter_top #(
    parameter int DEPTH = 64,
    parameter int FRAC_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // sample[31:0], capacity[38:32]
    input  wire logic [1:0]  s_axis_tuser,  // kind
    input  wire logic        s_axis_tlast,  // batch_end
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,  // count, ok, index, log_ratio, log_rank
    output logic             m_axis_tlast   // final_result
);
    import lrs_pkg::*;
    t_cmd w_in, w_q;
    t_res w_res;
    logic w_full, w_empty, w_pop;

    assign w_in.kind      = t_kind'(s_axis_tuser);
    assign w_in.sample    = s_axis_tdata[31:0];
    assign w_in.batch_end = s_axis_tlast;
    assign w_in.capacity  = s_axis_tdata[38:32];
    assign s_axis_tready  = !w_full;

    lrs_fifo u_q (.i_clk, .i_rst_n, .i_wr(s_axis_tvalid), .i_data(w_in),
        .o_full(w_full), .i_rd(w_pop), .o_empty(w_empty), .o_data(w_q));

    lrs_back #(.DEPTH(DEPTH), .FRAC_BITS(FRAC_BITS)) u_back (.i_clk, .i_rst_n,
        .i_empty(w_empty), .i_cmd(w_q), .o_pop(w_pop), .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready), .o_res(w_res));

    assign m_axis_tdata = {5'd0, w_res.log_rank, w_res.log_ratio, w_res.index,
                           w_res.ok, w_res.count};
    assign m_axis_tlast = w_res.final_result;
endmodule
`default_nettype wire
